// ===== hdl/hkdf_pkg.sv =====
// ----------------------------------------------------------------------------
// HKDF-SHA256 package
// Shared constants, round tables, command struct and SHA-256 helper functions.
// ----------------------------------------------------------------------------
package hkdf_pkg;

  localparam int unsigned MaxIdBytesDef   = 16;
  localparam int unsigned ExpandBlocksDef = 3;
  localparam int unsigned KeyWords        = 12;
  localparam int unsigned ExpIdxW         = 3;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] HashInit [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] MasterKey [4] = '{
    32'h9a759cf2, 32'hc4f7caff, 32'h222cb976, 32'h9b41bc96
  };

  localparam logic [31:0] IpadWord = 32'h36363636;
  localparam logic [31:0] OpadWord = 32'h5c5c5c5c;
  localparam logic [7:0]  PadByte  = 8'h80;
  localparam logic [6:0]  InfoLen  = 7'd7;
  localparam logic [6:0]  HashLen  = 7'd32;

  typedef struct packed {
    logic               take_byte;
    logic               clr_id;
    logic               h_init;
    logic               v_load;
    logic               rnd_en;
    logic [5:0]         rnd;
    logic               h_add;
    logic               outer;
    logic               expand;
    logic               blk;
    logic [ExpIdxW-1:0] exp_idx;
    logic               save_inner;
    logic               save_prk;
    logic               save_prev;
    logic               out_load;
    logic [1:0]         out_sel;
    logic [3:0]         out_idx;
    logic               out_last;
  } hkdf_cmd_t;

  function automatic logic [7:0] info_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h52;
      3'd1:    b = 8'h46;
      3'd2:    b = 8'h49;
      3'd3:    b = 8'h44;
      3'd4:    b = 8'h2d;
      3'd5:    b = 8'h41;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

// ===== hdl/hkdf_in_if.sv =====
// ----------------------------------------------------------------------------
// Identifier byte channel
// Valid/ready channel carrying one identifier byte and its last flag.
// ----------------------------------------------------------------------------
interface hkdf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] uid_byte;
  logic       uid_last;

  modport source (output valid, output uid_byte, output uid_last, input ready);
  modport sink (input valid, input uid_byte, input uid_last, output ready);
endinterface

// ===== hdl/hkdf_out_if.sv =====
// ----------------------------------------------------------------------------
// Derived key channel
// Valid/ready channel carrying one 64-bit key word and its tags.
// ----------------------------------------------------------------------------
interface hkdf_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] key_word;
  logic [3:0]  word_index;
  logic        last_word;
  logic        uid_overflow;

  modport source (output valid, output key_word, output word_index, output last_word,
                  output uid_overflow, input ready);
  modport sink (input valid, input key_word, input word_index, input last_word,
                input uid_overflow, output ready);
endinterface

// ===== hdl/hkdf_dp.sv =====
// ----------------------------------------------------------------------------
// HKDF datapath
// Identifier buffer, HMAC block builder, SHA-256 round engine and key output.
// ----------------------------------------------------------------------------
module hkdf_dp #(
  parameter int unsigned MAX_ID_BYTES = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hkdf_pkg::hkdf_cmd_t cmd_i,
  input  logic [7:0]        uid_byte_i,
  output logic [63:0]       key_word_o,
  output logic [3:0]        word_index_o,
  output logic              last_word_o,
  output logic              uid_overflow_o
);
  import hkdf_pkg::*;

  localparam int unsigned IdWords = (MAX_ID_BYTES + 3) / 4;
  localparam int unsigned IdwW    = (IdWords > 1) ? $clog2(IdWords) : 1;
  localparam int unsigned CntW    = $clog2(MAX_ID_BYTES + 1);

  logic [31:0]     id_q [IdWords];
  logic [CntW-1:0] cnt_q;
  logic            ovf_q;
  logic [31:0]     h_q [8];
  logic [31:0]     v_q [8];
  logic [31:0]     win_q [16];
  logic [31:0]     prk_q [8];
  logic [31:0]     prev_q [8];
  logic [31:0]     inner_q [8];
  logic [63:0]     key_word_q;
  logic [3:0]      word_index_q;
  logic            last_word_q;
  logic            uid_overflow_q;

  logic [3:0]  t;
  logic [31:0] id_word, prev_word, inner_word, key_w, msg_w, gen_w, sched_w, w_t;
  logic [31:0] t1, t2;
  logic [6:0]  cntx, info_s, q, r, len_b;
  logic [7:0]  mb;
  logic [IdwW-1:0] wr_idx;
  logic [1:0]  wr_ln;

  assign t      = cmd_i.rnd[3:0];
  assign cntx   = 7'(cnt_q);
  assign wr_idx = cnt_q[IdwW+1:2];
  assign wr_ln  = cnt_q[1:0];

  always_comb begin
    id_word    = (32'(t) < IdWords) ? id_q[t[IdwW-1:0]] : '0;
    prev_word  = prev_q[t[2:0]];
    inner_word = inner_q[t[2:0]];
    if (cmd_i.expand) begin
      key_w = t[3] ? '0 : prk_q[t[2:0]];
    end else begin
      key_w = (t[3:2] == 2'd0) ? MasterKey[t[1:0]] : '0;
    end
    info_s = (cmd_i.exp_idx != '0) ? HashLen : 7'd0;
    if (cmd_i.outer) begin
      len_b = 7'd96;
    end else if (cmd_i.expand) begin
      len_b = 7'd64 + info_s + InfoLen + 7'd1;
    end else begin
      len_b = 7'd64 + cntx;
    end
    msg_w = '0;
    for (int k = 0; k < 4; k++) begin
      q  = {1'b0, t, 2'(k)};
      r  = q - info_s;
      mb = 8'h00;
      if (cmd_i.outer) begin
        if (q < HashLen) begin
          mb = inner_word[8*(3-k) +: 8];
        end else if (q == HashLen) begin
          mb = PadByte;
        end
      end else if (cmd_i.expand) begin
        if (q < info_s) begin
          mb = prev_word[8*(3-k) +: 8];
        end else if (r < InfoLen) begin
          mb = info_byte(r[2:0]);
        end else if (r == InfoLen) begin
          mb = 8'({1'b0, cmd_i.exp_idx} + 4'd1);
        end else if (r == InfoLen + 7'd1) begin
          mb = PadByte;
        end
      end else begin
        if (q < cntx) begin
          mb = id_word[8*(3-k) +: 8];
        end else if (q == cntx) begin
          mb = PadByte;
        end
      end
      msg_w[8*(3-k) +: 8] = mb;
    end
    if (t == 4'd15) begin
      msg_w = {22'd0, len_b, 3'd0};
    end
    gen_w   = cmd_i.blk ? msg_w : (key_w ^ (cmd_i.outer ? OpadWord : IpadWord));
    sched_w = ssig1(win_q[14]) + win_q[9] + ssig0(win_q[1]) + win_q[0];
    w_t     = (cmd_i.rnd < 6'd16) ? gen_w : sched_w;
    t1 = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
       + RoundK[cmd_i.rnd] + w_t;
    t2 = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else if (cmd_i.clr_id) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else if (cmd_i.take_byte) begin
      if (32'(cnt_q) < MAX_ID_BYTES) begin
        cnt_q <= cnt_q + 1'b1;
      end else begin
        ovf_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_byte && (32'(cnt_q) < MAX_ID_BYTES)) begin
      id_q[wr_idx][{~wr_ln, 3'b000} +: 8] <= uid_byte_i;
    end
    for (int i = 0; i < 8; i++) begin
      if (cmd_i.h_init) begin
        h_q[i] <= HashInit[i];
      end else if (cmd_i.h_add) begin
        h_q[i] <= h_q[i] + v_q[i];
      end
      if (cmd_i.save_inner) inner_q[i] <= h_q[i];
      if (cmd_i.save_prk)   prk_q[i]   <= h_q[i];
      if (cmd_i.save_prev)  prev_q[i]  <= h_q[i];
    end
    if (cmd_i.v_load) begin
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end else if (cmd_i.rnd_en) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
    if (cmd_i.rnd_en) begin
      for (int i = 0; i < 15; i++) win_q[i] <= win_q[i+1];
      win_q[15] <= w_t;
    end
    if (cmd_i.out_load) begin
      key_word_q     <= {prev_q[{cmd_i.out_sel, 1'b0}], prev_q[{cmd_i.out_sel, 1'b1}]};
      word_index_q   <= cmd_i.out_idx;
      last_word_q    <= cmd_i.out_last;
      uid_overflow_q <= ovf_q;
    end
  end

  assign key_word_o     = key_word_q;
  assign word_index_o   = word_index_q;
  assign last_word_o    = last_word_q;
  assign uid_overflow_o = uid_overflow_q;

endmodule

// ===== hdl/hkdf_ctrl.sv =====
// ----------------------------------------------------------------------------
// HKDF controller
// Sequences byte intake, the HMAC extract and expand hashes, and key word output.
// ----------------------------------------------------------------------------
module hkdf_ctrl #(
  parameter int unsigned EXPAND_BLOCKS = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_last_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output hkdf_pkg::hkdf_cmd_t cmd_o
);
  import hkdf_pkg::*;

  localparam int unsigned NWords = (4 * EXPAND_BLOCKS > KeyWords) ? KeyWords
                                                                  : 4 * EXPAND_BLOCKS;

  typedef enum logic [2:0] {
    ST_IDLE, ST_HINIT, ST_BSTART, ST_ROUND, ST_HADD, ST_SAVE, ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    PH_EXT_IN, PH_EXT_OUT, PH_EXP_IN, PH_EXP_OUT
  } phase_e;

  state_e             state_q;
  phase_e             phase_q;
  logic               blk_q;
  logic [5:0]         rnd_q;
  logic [ExpIdxW-1:0] b_q;
  logic [1:0]         i_q;
  logic [3:0]         gi_q;
  logic               out_valid_q;

  logic take, slot_free, ld, blk_done;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign take        = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign ld          = (state_q == ST_EMIT) && (gi_q < 4'(NWords)) && slot_free;
  assign blk_done    = (gi_q >= 4'(NWords)) || (slot_free && (i_q == 2'd3));
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o            = '0;
    cmd_o.take_byte  = take;
    cmd_o.h_init     = (state_q == ST_HINIT);
    cmd_o.v_load     = (state_q == ST_BSTART);
    cmd_o.rnd_en     = (state_q == ST_ROUND);
    cmd_o.rnd        = rnd_q;
    cmd_o.h_add      = (state_q == ST_HADD);
    cmd_o.outer      = (phase_q == PH_EXT_OUT) || (phase_q == PH_EXP_OUT);
    cmd_o.expand     = (phase_q == PH_EXP_IN) || (phase_q == PH_EXP_OUT);
    cmd_o.blk        = blk_q;
    cmd_o.exp_idx    = b_q;
    cmd_o.save_inner = (state_q == ST_SAVE) &&
                       ((phase_q == PH_EXT_IN) || (phase_q == PH_EXP_IN));
    cmd_o.save_prk   = (state_q == ST_SAVE) && (phase_q == PH_EXT_OUT);
    cmd_o.save_prev  = (state_q == ST_SAVE) && (phase_q == PH_EXP_OUT);
    cmd_o.out_load   = ld;
    cmd_o.out_sel    = i_q;
    cmd_o.out_idx    = gi_q;
    cmd_o.out_last   = (gi_q == 4'(NWords - 1));
    cmd_o.clr_id     = (state_q == ST_EMIT) && blk_done &&
                       (b_q == ExpIdxW'(EXPAND_BLOCKS - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_EXT_IN;
      blk_q       <= 1'b0;
      rnd_q       <= '0;
      b_q         <= '0;
      i_q         <= '0;
      gi_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ld) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (take && in_last_i) begin
            phase_q <= PH_EXT_IN;
            b_q     <= '0;
            gi_q    <= '0;
            state_q <= ST_HINIT;
          end
        end
        ST_HINIT: begin
          blk_q   <= 1'b0;
          state_q <= ST_BSTART;
        end
        ST_BSTART: begin
          rnd_q   <= '0;
          state_q <= ST_ROUND;
        end
        ST_ROUND: begin
          rnd_q <= rnd_q + 1'b1;
          if (rnd_q == 6'd63) begin
            state_q <= ST_HADD;
          end
        end
        ST_HADD: begin
          if (!blk_q) begin
            blk_q   <= 1'b1;
            state_q <= ST_BSTART;
          end else begin
            state_q <= ST_SAVE;
          end
        end
        ST_SAVE: begin
          unique case (phase_q)
            PH_EXT_IN: begin
              phase_q <= PH_EXT_OUT;
              state_q <= ST_HINIT;
            end
            PH_EXT_OUT: begin
              phase_q <= PH_EXP_IN;
              state_q <= ST_HINIT;
            end
            PH_EXP_IN: begin
              phase_q <= PH_EXP_OUT;
              state_q <= ST_HINIT;
            end
            default: begin
              i_q     <= '0;
              state_q <= ST_EMIT;
            end
          endcase
        end
        ST_EMIT: begin
          if (ld) begin
            i_q  <= i_q + 1'b1;
            gi_q <= gi_q + 1'b1;
          end
          if (blk_done) begin
            if (b_q == ExpIdxW'(EXPAND_BLOCKS - 1)) begin
              state_q <= ST_IDLE;
            end else begin
              b_q     <= b_q + 1'b1;
              phase_q <= PH_EXP_IN;
              state_q <= ST_HINIT;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/hkdf_sha256_key_derivation.sv =====
// ----------------------------------------------------------------------------
// HKDF-SHA256 key derivation
// Collects identifier bytes, derives a 96-byte key by HMAC-SHA256 extract and
// expand, and emits it as twelve 64-bit words.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                          transfer when
//  id_i     in   uid_byte, uid_last                               valid && ready
//  key_o    out  key_word, word_index, last_word, uid_overflow    valid && ready
//
//  A byte without the last flag starts no hashing. The last byte starts eight
//  SHA-256 hashes of two blocks each on one shared round engine; each hash runs
//  init, then load, 64 rounds and add for each block, then save. The output
//  register holds a word until it is taken; a stall there holds the sequencer.
//  New bytes are taken only between derivations. No clearing pass after reset.
// ----------------------------------------------------------------------------
module hkdf_sha256_key_derivation #(
  parameter int unsigned MAX_ID_BYTES  = hkdf_pkg::MaxIdBytesDef,
  parameter int unsigned EXPAND_BLOCKS = hkdf_pkg::ExpandBlocksDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  hkdf_in_if.sink   id_i,
  hkdf_out_if.source key_o
);
  import hkdf_pkg::*;

  hkdf_cmd_t cmd;

  hkdf_ctrl #(
    .EXPAND_BLOCKS(EXPAND_BLOCKS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (id_i.valid),
    .in_last_i  (id_i.uid_last),
    .in_ready_o (id_i.ready),
    .out_ready_i(key_o.ready),
    .out_valid_o(key_o.valid),
    .cmd_o      (cmd)
  );

  hkdf_dp #(
    .MAX_ID_BYTES(MAX_ID_BYTES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .uid_byte_i    (id_i.uid_byte),
    .key_word_o    (key_o.key_word),
    .word_index_o  (key_o.word_index),
    .last_word_o   (key_o.last_word),
    .uid_overflow_o(key_o.uid_overflow)
  );

endmodule
